[src/lin_master_frame_encoder_macros.svh]
// Assertion helpers shared by the encoder modules.
// Each expects clk and rst_n in scope.
`ifndef LIN_MASTER_FRAME_ENCODER_MACROS_SVH
`define LIN_MASTER_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication.
`define LMFE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LMFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/lmfe_pkg.sv]
package lmfe_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [5:0] ID_MASK    = 6'h3F;
  localparam logic [4:0] BREAK_RST  = 5'd13;

  localparam logic KIND_BREAK = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_DATA   = 1'b1;

  // One classified item: which symbols to send and their values.
  typedef struct packed {
    logic       hdr;       // break, sync, PID
    logic [4:0] brk;
    logic [7:0] pid;
    logic       has_data;
    logic [7:0] data;
    logic       has_sum;
    logic [7:0] csum;
  } job_t;

  // P0 = id0^id1^id2^id4 in bit 6, P1 = ~(id1^id3^id4^id5) in bit 7
  function automatic logic [7:0] protected_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id & ID_MASK};
  endfunction

endpackage

[src/lmfe_in_if.sv]
interface lmfe_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [5:0] frame_id;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, action, frame_id, data_byte, last_byte, input ready);
  modport sink   (input valid, action, frame_id, data_byte, last_byte, output ready);
endinterface

[src/lmfe_out_if.sv]
interface lmfe_out_if;
  logic       valid;
  logic       ready;
  logic       symbol_kind;
  logic [7:0] symbol_value;
  logic       last_of_run;

  modport source (output valid, symbol_kind, symbol_value, last_of_run, input ready);
  modport sink   (input valid, symbol_kind, symbol_value, last_of_run, output ready);
endinterface

[src/lmfe_front.sv]
`include "lin_master_frame_encoder_macros.svh"

module lmfe_front (
  input  logic         clk,
  input  logic         rst_n,
  lmfe_in_if.sink      in_if,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_data,
  input  logic         q_full,
  output logic         q_push,
  output lmfe_pkg::job_t q_job
);
  import lmfe_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [4:0] break_bits_r;
  logic [8:0] raw_sum;
  logic [7:0] folded;
  logic       acc;

  assign in_if.ready = !q_full;
  assign acc         = in_if.valid && !q_full;
  assign q_push      = acc;

  // end-around carry: raw sum never exceeds 510
  assign raw_sum = {1'b0, sum_r} + {1'b0, in_if.data_byte};
  assign folded  = raw_sum[7:0] + {7'd0, raw_sum[8]};

  always_comb begin
    q_job.hdr      = (in_if.action == ACT_HEADER) || !in_frame_r;
    q_job.brk      = break_bits_r;
    q_job.pid      = protected_id(in_if.frame_id);
    q_job.has_data = (in_if.action == ACT_DATA);
    q_job.data     = in_if.data_byte;
    q_job.has_sum  = (in_if.action == ACT_DATA) && in_if.last_byte;
    q_job.csum     = ~folded;

    in_frame_nxt = in_frame_r;
    sum_nxt      = sum_r;
    if (acc) begin
      if (in_if.action == ACT_HEADER || in_if.last_byte) begin
        in_frame_nxt = 1'b0;
        sum_nxt      = '0;
      end else begin
        in_frame_nxt = 1'b1;
        sum_nxt      = folded;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      sum_r        <= '0;
      break_bits_r <= BREAK_RST;
    end else begin
      in_frame_r <= in_frame_nxt;
      sum_r      <= sum_nxt;
      if (cfg_we) begin
        break_bits_r <= cfg_data;
      end
    end
  end

  // closed frame always carries a cleared sum
  `LMFE_ASSERT(fr_sum_clear, !in_frame_r, sum_r == 8'd0, "sum not clear outside frame")
  `LMFE_ASSERT_NEXT(fr_close, acc && in_if.last_byte, !in_frame_r, "frame left open")
  `LMFE_ASSERT(fr_hdr_first, acc && !in_frame_r, q_job.hdr, "first byte without header")

endmodule

[src/lmfe_queue.sv]
`include "lin_master_frame_encoder_macros.svh"

module lmfe_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lmfe_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lmfe_pkg::job_t head_job
);
  import lmfe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `LMFE_ASSERT(q_bound, 1'b1, count_r <= FULL_CNT, "queue count out of range")
  `LMFE_ASSERT(q_no_drop, push, !full, "push into full queue")

endmodule

[src/lmfe_back.sv]
`include "lin_master_frame_encoder_macros.svh"

module lmfe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  lmfe_pkg::job_t head_job,
  output logic           pop,
  lmfe_out_if.source     out_if
);
  import lmfe_pkg::*;

  typedef enum logic [2:0] {
    ST_START,
    ST_BRK,
    ST_SYNC,
    ST_PID,
    ST_DATA,
    ST_SUM
  } step_t;

  step_t      step_r, cur, after;
  logic       slot_free, fire, done;
  logic       valid_r;
  logic       kind_r, kind_nxt;
  logic [7:0] value_r, value_nxt;
  logic       last_r;

  assign slot_free = !valid_r || out_if.ready;
  assign fire      = head_valid && slot_free;
  assign done      = (after == ST_START);
  assign pop       = fire && done;

  always_comb begin
    cur = (step_r == ST_START) ? (head_job.hdr ? ST_BRK : ST_DATA) : step_r;
    unique case (cur)
      ST_BRK:  after = ST_SYNC;
      ST_SYNC: after = ST_PID;
      ST_PID:  after = head_job.has_data ? ST_DATA : ST_START;
      ST_DATA: after = head_job.has_sum ? ST_SUM : ST_START;
      default: after = ST_START;
    endcase
    unique case (cur)
      ST_BRK: begin
        kind_nxt  = KIND_BREAK;
        value_nxt = {3'd0, head_job.brk};
      end
      ST_SYNC: begin
        kind_nxt  = KIND_BYTE;
        value_nxt = SYNC_BYTE;
      end
      ST_PID: begin
        kind_nxt  = KIND_BYTE;
        value_nxt = head_job.pid;
      end
      ST_SUM: begin
        kind_nxt  = KIND_BYTE;
        value_nxt = head_job.csum;
      end
      default: begin
        kind_nxt  = KIND_BYTE;
        value_nxt = head_job.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_START;
      valid_r <= 1'b0;
    end else begin
      if (slot_free) begin
        valid_r <= head_valid;
      end
      if (fire) begin
        step_r  <= after;
        kind_r  <= kind_nxt;
        value_r <= value_nxt;
        last_r  <= done;
      end
    end
  end

  assign out_if.valid        = valid_r;
  assign out_if.symbol_kind  = kind_r;
  assign out_if.symbol_value = value_r;
  assign out_if.last_of_run  = last_r;

  // a break can only open a job
  `LMFE_ASSERT(bk_break_first, fire && kind_nxt == KIND_BREAK, step_r == ST_START,
               "break inside a run")
  `LMFE_ASSERT_NEXT(bk_pop_last, pop, out_if.valid && out_if.last_of_run,
                    "job retired without final symbol")

endmodule

[src/lin_master_frame_encoder.sv]
// Channel  | Dir | Beat contents
// ---------+-----+----------------------------------------------------
// in_if    | in  | action, frame_id, data_byte, last_byte
// out_if   | out | symbol_kind, symbol_value, last_of_run
// cfg_*    | in  | cfg_we / cfg_data: break length, no read-back
//
// One in_if beat gives 1 to 5 out_if beats: header-only 3, first byte 4 (5 if also last),
// later byte 1 (2 if last). One symbol per cycle while out_if is ready, set by the
// emitter's single output register. Front accepts one beat per cycle while the job queue
// (QUEUE_DEPTH) has room. Reset (rst_n low, synchronous) closes any frame, clears the sum
// and queue, and restores break length 13.
// An out_if stall holds the output register and backs up through the queue.
module lin_master_frame_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  lmfe_in_if.sink    in_if,
  lmfe_out_if.source out_if,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data
);
  import lmfe_pkg::*;

  // classified job handed from front to emitter
  job_t push_job, head_job;
  logic q_push, q_full, q_pop, head_valid;

  // front: handshake, frame state, running checksum, break register
  lmfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // short queue so input and output stall independently
  lmfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: steps through break, sync, PID, data, checksum
  lmfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_if     (out_if)
  );

endmodule
